// ===== rtl/mono_bitmap_color_expand_unit_assert.svh =====
// Assertion macros used by the checker file mbce_checker.sv.
`ifndef MONO_BITMAP_COLOR_EXPAND_UNIT_ASSERT_SVH
`define MONO_BITMAP_COLOR_EXPAND_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MBCE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MBCE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/mbce_pkg.sv =====
`default_nettype none

package mbce_pkg;

  localparam int ADDR_W     = 32;
  localparam int PIX_ADDR_W = 32;
  localparam int COLOR_W    = 32;
  localparam int ORG_W      = 16;
  localparam int PITCH_W    = 16;
  localparam int BPP_W      = 3;
  localparam int ROW_W      = 10;
  localparam int BYTE_W     = 8;
  localparam int PIXIDX_W   = $clog2(BYTE_W);
  localparam int OFFS_W     = ROW_W + PIXIDX_W + BPP_W;
  localparam int STEP_W     = PIXIDX_W + BPP_W;
  localparam int PROD_Y_W   = ORG_W + PITCH_W;
  localparam int PROD_X_W   = ORG_W + BPP_W;

  localparam int REG_IDX_W  = 3;
  localparam int APB_ADDR_W = REG_IDX_W + 2;
  localparam int APB_DATA_W = 32;

  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [COLOR_W-1:0] NO_COLOR     = 32'h9001_1337;
  localparam logic [COLOR_W-1:0] INVERT_COLOR = 32'h4266_6616;

  localparam logic [BPP_W-1:0] BPP_RESET       = 3'd4;
  localparam logic [ROW_W-1:0] ROW_BYTES_RESET = 10'd1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BASE      = 3'd0,
    REG_ORIGIN_X  = 3'd1,
    REG_ORIGIN_Y  = 3'd2,
    REG_PITCH     = 3'd3,
    REG_BPP       = 3'd4,
    REG_FG        = 3'd5,
    REG_BG        = 3'd6,
    REG_ROW_BYTES = 3'd7
  } reg_idx_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_INVERT = 1'b1
  } op_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [ORG_W-1:0]   origin_x;
    logic [ORG_W-1:0]   origin_y;
    logic [PITCH_W-1:0] pitch;
    logic [BPP_W-1:0]   bpp;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic [ROW_W-1:0]   row_bytes;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [BPP_W-1:0]   bpp;
    logic [BYTE_W-1:0]  mask;
    logic [BYTE_W-1:0]  bits;
    logic               fg_inv;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
  } qent_t;

endpackage

`default_nettype wire

// ===== rtl/mbce_regs.sv =====
`default_nettype none

module mbce_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mbce_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mbce_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mbce_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output mbce_pkg::cfg_t                  cfg
);
  import mbce_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base      <= '0;
      cfg_r.origin_x  <= '0;
      cfg_r.origin_y  <= '0;
      cfg_r.pitch     <= '0;
      cfg_r.bpp       <= BPP_RESET;
      cfg_r.fg        <= '0;
      cfg_r.bg        <= '0;
      cfg_r.row_bytes <= ROW_BYTES_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_BASE:      cfg_r.base      <= pwdata[ADDR_W-1:0];
        REG_ORIGIN_X:  cfg_r.origin_x  <= pwdata[ORG_W-1:0];
        REG_ORIGIN_Y:  cfg_r.origin_y  <= pwdata[ORG_W-1:0];
        REG_PITCH:     cfg_r.pitch     <= pwdata[PITCH_W-1:0];
        REG_BPP:       cfg_r.bpp       <= pwdata[BPP_W-1:0];
        REG_FG:        cfg_r.fg        <= pwdata[COLOR_W-1:0];
        REG_BG:        cfg_r.bg        <= pwdata[COLOR_W-1:0];
        REG_ROW_BYTES: cfg_r.row_bytes <= pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BASE:      prdata = APB_DATA_W'(cfg_r.base);
      REG_ORIGIN_X:  prdata = APB_DATA_W'(cfg_r.origin_x);
      REG_ORIGIN_Y:  prdata = APB_DATA_W'(cfg_r.origin_y);
      REG_PITCH:     prdata = APB_DATA_W'(cfg_r.pitch);
      REG_BPP:       prdata = APB_DATA_W'(cfg_r.bpp);
      REG_FG:        prdata = APB_DATA_W'(cfg_r.fg);
      REG_BG:        prdata = APB_DATA_W'(cfg_r.bg);
      REG_ROW_BYTES: prdata = APB_DATA_W'(cfg_r.row_bytes);
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mbce_fifo.sv =====
`default_nettype none

module mbce_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_vld,
  input  mbce_pkg::qent_t wr_data,
  output logic            wr_rdy,
  output logic            rd_vld,
  output mbce_pkg::qent_t rd_data,
  input  logic            rd_en
);
  import mbce_pkg::*;

  qent_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_wr;
  logic              do_rd;

  assign wr_rdy  = count_r != (QPTR_W+1)'(QDEPTH);
  assign rd_vld  = count_r != '0;
  assign do_wr   = wr_vld & wr_rdy;
  assign do_rd   = rd_en & rd_vld;
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (!do_wr && do_rd) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slot_r[wr_ptr_r] <= wr_data;
  end

endmodule

`default_nettype wire

// ===== rtl/mbce_front.sv =====
`default_nettype none

module mbce_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mbce_pkg::cfg_t              cfg,
  input  logic                        push,
  output logic                        full,
  input  logic [mbce_pkg::BYTE_W-1:0] bitmap_byte,
  input  logic                        last_byte,
  output logic                        q_wr_vld,
  output mbce_pkg::qent_t             q_wr_data,
  input  logic                        q_wr_rdy
);
  import mbce_pkg::*;

  typedef enum logic {
    ST_RUN,
    ST_SUM
  } st_t;

  st_t                  st_r;
  logic                 hold_vld_r;
  logic [BYTE_W-1:0]    hold_bits_r;
  logic                 hold_last_r;
  logic                 at_start_r;
  logic [ADDR_W-1:0]    row_start_r;
  logic [ROW_W-1:0]     byte_in_row_r;
  logic [PROD_Y_W-1:0]  prod_y_r;
  logic [PROD_X_W-1:0]  prod_x_r;

  logic [BYTE_W-1:0]    mask;
  logic [OFFS_W-1:0]    offs;
  logic                 fg_live;
  logic                 bg_live;
  logic                 row_active;
  logic                 row_end;
  logic                 go;
  logic                 need_push;
  logic                 consume;
  logic                 accept;

  assign fg_live    = cfg.fg != NO_COLOR;
  assign bg_live    = cfg.bg != NO_COLOR;
  assign row_active = cfg.row_bytes != '0;

  always_comb begin
    for (int i = 0; i < BYTE_W; i++) begin
      mask[i] = hold_bits_r[i] ? fg_live : bg_live;
    end
  end

  assign offs      = OFFS_W'({byte_in_row_r, PIXIDX_W'(0)}) * OFFS_W'(cfg.bpp);
  assign row_end   = ({1'b0, byte_in_row_r} + 1'b1) >= {1'b0, cfg.row_bytes};
  assign go        = hold_vld_r && !at_start_r && (st_r == ST_RUN);
  assign need_push = row_active && (mask != '0);
  assign consume   = go && (!need_push || q_wr_rdy);
  assign q_wr_vld  = go && need_push;
  assign full      = hold_vld_r && !consume;
  assign accept    = push && !full;

  assign q_wr_data.addr   = row_start_r + ADDR_W'(offs);
  assign q_wr_data.bpp    = cfg.bpp;
  assign q_wr_data.mask   = mask;
  assign q_wr_data.bits   = hold_bits_r;
  assign q_wr_data.fg_inv = cfg.fg == INVERT_COLOR;
  assign q_wr_data.fg     = cfg.fg;
  assign q_wr_data.bg     = cfg.bg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= ST_RUN;
      hold_vld_r    <= 1'b0;
      at_start_r    <= 1'b1;
      row_start_r   <= '0;
      byte_in_row_r <= '0;
    end else begin
      unique case (st_r)
        ST_RUN: begin
          if (hold_vld_r && at_start_r) st_r <= ST_SUM;
        end
        ST_SUM: begin
          row_start_r   <= cfg.base + ADDR_W'(prod_y_r) + ADDR_W'(prod_x_r);
          byte_in_row_r <= '0;
          at_start_r    <= 1'b0;
          st_r          <= ST_RUN;
        end
      endcase
      if (consume) begin
        if (row_active) begin
          if (row_end) begin
            byte_in_row_r <= '0;
            row_start_r   <= row_start_r + ADDR_W'(cfg.pitch);
          end else begin
            byte_in_row_r <= byte_in_row_r + 1'b1;
          end
        end
        if (hold_last_r) at_start_r <= 1'b1;
      end
      if (accept) begin
        hold_vld_r <= 1'b1;
      end else if (consume) begin
        hold_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_bits_r <= bitmap_byte;
      hold_last_r <= last_byte;
    end
    prod_y_r <= PROD_Y_W'(cfg.origin_y) * PROD_Y_W'(cfg.pitch);
    prod_x_r <= PROD_X_W'(cfg.origin_x) * PROD_X_W'(cfg.bpp);
  end

endmodule

`default_nettype wire

// ===== rtl/mbce_back.sv =====
`default_nettype none

module mbce_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_rd_vld,
  input  mbce_pkg::qent_t                 q_rd_data,
  output logic                            q_rd_en,
  input  logic                            pop,
  output logic                            out_empty,
  output logic [mbce_pkg::PIX_ADDR_W-1:0] out_pixel_address,
  output logic                            out_operation,
  output logic [mbce_pkg::COLOR_W-1:0]    out_pixel_color,
  output logic                            out_last_of_run
);
  import mbce_pkg::*;

  qent_t                cur_r;
  logic [BYTE_W-1:0]    cur_mask_r;
  logic                 cur_vld_r;
  logic                 out_vld_r;
  logic [ADDR_W-1:0]    out_addr_r;
  op_t                  out_op_r;
  logic [COLOR_W-1:0]   out_color_r;
  logic                 out_last_r;

  logic [PIXIDX_W-1:0]  sel;
  logic [PIXIDX_W-1:0]  pos;
  logic [BYTE_W-1:0]    rest_mask;
  logic                 run_last;
  logic                 advance;
  logic                 bit_set;
  op_t                  op;
  logic [COLOR_W-1:0]   color;
  logic [ADDR_W-1:0]    addr;

  always_comb begin
    sel = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (cur_mask_r[i]) sel = PIXIDX_W'(i);
    end
  end

  assign pos       = PIXIDX_W'(BYTE_W - 1) - sel;
  assign rest_mask = cur_mask_r & ~(BYTE_W'(1) << sel);
  assign run_last  = rest_mask == '0;
  assign advance   = cur_vld_r && (!out_vld_r || pop);
  assign q_rd_en   = q_rd_vld && (!cur_vld_r || (advance && run_last));
  assign bit_set   = cur_r.bits[sel];
  assign op        = (bit_set && cur_r.fg_inv) ? OP_INVERT : OP_WRITE;
  assign color     = bit_set ? (cur_r.fg_inv ? '0 : cur_r.fg) : cur_r.bg;
  assign addr      = cur_r.addr + ADDR_W'(STEP_W'(pos) * STEP_W'(cur_r.bpp));

  assign out_empty         = !out_vld_r;
  assign out_pixel_address = PIX_ADDR_W'(out_addr_r);
  assign out_operation     = out_op_r;
  assign out_pixel_color   = out_color_r;
  assign out_last_of_run   = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (q_rd_en) begin
        cur_vld_r <= 1'b1;
      end else if (advance && run_last) begin
        cur_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd_en) begin
      cur_r      <= q_rd_data;
      cur_mask_r <= q_rd_data.mask;
    end else if (advance) begin
      cur_mask_r <= rest_mask;
    end
    if (advance) begin
      out_addr_r  <= addr;
      out_op_r    <= op;
      out_color_r <= color;
      out_last_r  <= run_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mono_bitmap_color_expand_unit.sv =====
// Channel     | Ports                                    | Transfer when
// ------------+------------------------------------------+-----------------------------
// bitmap in   | push, full, in_bitmap_byte, in_last_byte | push && !full
// pixel ops   | pop, empty, out_pixel_address, ...       | pop && !empty
// registers   | psel, penable, pwrite, paddr, pwdata,... | psel && penable && pwrite
//
// One pixel operation leaves per cycle while pop is held and work waits; a byte holds
// the back end until all its operations (up to 8) are out, and one that yields none
// passes the front unqueued. The first byte of a bitmap waits while ST_SUM adds the
// registered origin products to base; later bytes enter the front one per cycle
// unless the queue is full. A two-entry queue separates front and back; either side
// stalls on its own. rst_n is synchronous, active low; no clearing pass follows reset.

`default_nettype none

module mono_bitmap_color_expand_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [mbce_pkg::BYTE_W-1:0]     in_bitmap_byte,
  input  logic                            in_last_byte,
  output logic                            empty,
  input  logic                            pop,
  output logic [mbce_pkg::PIX_ADDR_W-1:0] out_pixel_address,
  output logic                            out_operation,
  output logic [mbce_pkg::COLOR_W-1:0]    out_pixel_color,
  output logic                            out_last_of_run,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mbce_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mbce_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mbce_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import mbce_pkg::*;

  cfg_t  cfg;
  qent_t q_wr_data;
  qent_t q_rd_data;
  logic  q_wr_vld;
  logic  q_wr_rdy;
  logic  q_rd_vld;
  logic  q_rd_en;

  mbce_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mbce_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .push        (push),
    .full        (full),
    .bitmap_byte (in_bitmap_byte),
    .last_byte   (in_last_byte),
    .q_wr_vld    (q_wr_vld),
    .q_wr_data   (q_wr_data),
    .q_wr_rdy    (q_wr_rdy)
  );

  mbce_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_vld  (q_wr_vld),
    .wr_data (q_wr_data),
    .wr_rdy  (q_wr_rdy),
    .rd_vld  (q_rd_vld),
    .rd_data (q_rd_data),
    .rd_en   (q_rd_en)
  );

  mbce_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_rd_vld          (q_rd_vld),
    .q_rd_data         (q_rd_data),
    .q_rd_en           (q_rd_en),
    .pop               (pop),
    .out_empty         (empty),
    .out_pixel_address (out_pixel_address),
    .out_operation     (out_operation),
    .out_pixel_color   (out_pixel_color),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

`default_nettype wire

// ===== rtl/mbce_checker.sv =====
`default_nettype none

`include "mono_bitmap_color_expand_unit_assert.svh"

module mbce_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            pop,
  input  logic                            empty,
  input  logic [mbce_pkg::PIX_ADDR_W-1:0] out_pixel_address,
  input  logic                            out_operation,
  input  logic [mbce_pkg::COLOR_W-1:0]    out_pixel_color,
  input  logic                            out_last_of_run
);
  import mbce_pkg::*;

  // hold a stalled result
  `MBCE_ASSERT_NXT(a_out_hold, !empty && !pop, !empty && $stable(out_pixel_address))

  // invert operations carry no color
  `MBCE_ASSERT_IMP(a_inv_zero, !empty && out_operation, out_pixel_color == '0)

  // results of one byte follow back to back
  `MBCE_ASSERT_NXT(a_run_dense, !empty && pop && !out_last_of_run, !empty)

endmodule

bind mono_bitmap_color_expand_unit mbce_checker u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .pop               (pop),
  .empty             (empty),
  .out_pixel_address (out_pixel_address),
  .out_operation     (out_operation),
  .out_pixel_color   (out_pixel_color),
  .out_last_of_run   (out_last_of_run)
);

`default_nettype wire

// ===== test/tb_mono_bitmap_color_expand_unit.sv =====
module tb_mono_bitmap_color_expand_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mbce_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RAND_PHASES   = 10;
  localparam int PHASE_ITEMS   = 47;

  typedef struct packed {
    logic [PIX_ADDR_W-1:0] addr;
    op_t                   op;
    logic [COLOR_W-1:0]    color;
    logic                  last;
  } pix_op_t;

  typedef struct {
    bit                    is_reg;
    reg_idx_t              idx;
    logic [APB_DATA_W-1:0] val;
    logic [BYTE_W-1:0]     bits;
    logic                  last;
    bit                    typed;
    pix_op_t               op;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  push = 1'b0;
  logic [BYTE_W-1:0]     in_bitmap_byte = '0;
  logic                  in_last_byte = 1'b0;
  logic                  pop = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;

  logic                  full;
  logic                  empty;
  logic [PIX_ADDR_W-1:0] out_pixel_address;
  logic                  out_operation;
  logic [COLOR_W-1:0]    out_pixel_color;
  logic                  out_last_of_run;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  cfg_t              cfg;
  logic [ADDR_W-1:0] row_base;
  logic [ROW_W-1:0]  row_byte_idx;
  bit                new_bitmap;
  pix_op_t           pix_ops_due[$];
  int                mismatches = 0;
  int                stall_left = 0;
  bit                no_gaps = 1'b0;

  mono_bitmap_color_expand_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_bitmap_byte    (in_bitmap_byte),
    .in_last_byte      (in_last_byte),
    .empty             (empty),
    .pop               (pop),
    .out_pixel_address (out_pixel_address),
    .out_operation     (out_operation),
    .out_pixel_color   (out_pixel_color),
    .out_last_of_run   (out_last_of_run),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 32'h0;
    if (r < 30) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic stim_row_t reg_row(reg_idx_t idx, logic [APB_DATA_W-1:0] val);
    stim_row_t s;
    s.is_reg = 1'b1;
    s.idx    = idx;
    s.val    = val;
    s.bits   = '0;
    s.last   = 1'b0;
    s.typed  = 1'b0;
    s.op     = '0;
    return s;
  endfunction

  function automatic stim_row_t item_row(logic [BYTE_W-1:0] bits, logic last);
    stim_row_t s;
    s.is_reg = 1'b0;
    s.idx    = REG_BASE;
    s.val    = '0;
    s.bits   = bits;
    s.last   = last;
    s.typed  = 1'b0;
    s.op     = '0;
    return s;
  endfunction

  function automatic stim_row_t typed_row(logic [BYTE_W-1:0] bits, logic last,
                                          logic [31:0] addr, op_t op, logic [31:0] color);
    stim_row_t s;
    s = item_row(bits, last);
    s.typed    = 1'b1;
    s.op.addr  = addr;
    s.op.op    = op;
    s.op.color = color;
    s.op.last  = 1'b1;
    return s;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  task automatic expand_byte(input logic [BYTE_W-1:0] bits, input logic last,
                             input bit record);
    pix_op_t run[$];
    pix_op_t r;
    bit      hit;
    int      b;
    if (new_bitmap) begin
      row_base = cfg.base + 32'(cfg.origin_y) * 32'(cfg.pitch)
                 + 32'(cfg.origin_x) * 32'(cfg.bpp);
      row_byte_idx = '0;
      new_bitmap = 1'b0;
    end
    if (cfg.row_bytes != '0) begin
      for (b = 0; b < 8; b++) begin
        r.addr = row_base + (32'(row_byte_idx) * 32'd8 + 32'(b)) * 32'(cfg.bpp);
        r.last = 1'b0;
        hit = 1'b1;
        if (bits[7-b]) begin
          if (cfg.fg == INVERT_COLOR) begin
            r.op    = OP_INVERT;
            r.color = '0;
          end else if (cfg.fg != NO_COLOR) begin
            r.op    = OP_WRITE;
            r.color = cfg.fg;
          end else begin
            hit = 1'b0;
          end
        end else if (cfg.bg != NO_COLOR) begin
          r.op    = OP_WRITE;
          r.color = cfg.bg;
        end else begin
          hit = 1'b0;
        end
        if (hit) run.push_back(r);
      end
      if (32'(row_byte_idx) + 32'd1 >= 32'(cfg.row_bytes)) begin
        row_byte_idx = '0;
        row_base = row_base + 32'(cfg.pitch);
      end else begin
        row_byte_idx = row_byte_idx + 1'b1;
      end
    end
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    if (record) begin
      foreach (run[i]) pix_ops_due.push_back(run[i]);
    end
    if (last) new_bitmap = 1'b1;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_BASE:      cfg.base      = val[ADDR_W-1:0];
      REG_ORIGIN_X:  cfg.origin_x  = val[ORG_W-1:0];
      REG_ORIGIN_Y:  cfg.origin_y  = val[ORG_W-1:0];
      REG_PITCH:     cfg.pitch     = val[PITCH_W-1:0];
      REG_BPP:       cfg.bpp       = val[BPP_W-1:0];
      REG_FG:        cfg.fg        = val[COLOR_W-1:0];
      REG_BG:        cfg.bg        = val[COLOR_W-1:0];
      REG_ROW_BYTES: cfg.row_bytes = val[ROW_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] bits, input logic last,
                           input bit typed, input pix_op_t typed_op);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push           <= 1'b1;
    in_bitmap_byte <= bits;
    in_last_byte   <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    expand_byte(bits, last, !typed);
    if (typed) pix_ops_due.push_back(typed_op);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (pix_ops_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    pix_op_t want;
    if (rst_n && pop && !empty) begin
      if (pix_ops_due.size() == 0) begin
        report_mismatch("unexpected transfer", out_pixel_address, '0);
      end else begin
        want = pix_ops_due.pop_front();
        if (out_pixel_address !== want.addr)
          report_mismatch("pixel_address", out_pixel_address, want.addr);
        if (out_operation !== want.op)
          report_mismatch("operation", 32'(out_operation), 32'(want.op));
        if (out_pixel_color !== want.color)
          report_mismatch("pixel_color", out_pixel_color, want.color);
        if (out_last_of_run !== want.last)
          report_mismatch("last_of_run", 32'(out_last_of_run), 32'(want.last));
      end
    end
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else begin
      pop <= 1'b1;
      stall_left = no_gaps ? 0 : pick_gap();
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || (psel && penable)) idle = 0;
      else idle++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   rows[$];
    int          ph;
    int          k;
    int          left;
    int          rb;
    int          r;
    logic        last;
    bit          dirty;
    cfg           = '0;
    cfg.bpp       = BPP_RESET;
    cfg.row_bytes = ROW_BYTES_RESET;
    row_base      = '0;
    row_byte_idx  = '0;
    new_bitmap    = 1'b1;
    dirty         = 1'b0;
    left          = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows = '{
      item_row(8'hA5, 1'b0),
      item_row(8'h00, 1'b1),
      reg_row(REG_BG, NO_COLOR),
      reg_row(REG_FG, 32'hFFFF_FFFF),
      reg_row(REG_BASE, 32'hFFFF_FFF0),
      typed_row(8'h80, 1'b1, 32'hFFFF_FFF0, OP_WRITE, 32'hFFFF_FFFF),
      typed_row(8'h01, 1'b1, 32'h0000_000C, OP_WRITE, 32'hFFFF_FFFF),
      reg_row(REG_FG, INVERT_COLOR),
      typed_row(8'h40, 1'b1, 32'hFFFF_FFF4, OP_INVERT, 32'h0),
      reg_row(REG_FG, NO_COLOR),
      item_row(8'hFF, 1'b1),
      reg_row(REG_BG, INVERT_COLOR),
      typed_row(8'hFE, 1'b1, 32'h0000_000C, OP_WRITE, INVERT_COLOR),
      reg_row(REG_FG, 32'h5A5A_5A5A),
      reg_row(REG_BG, 32'hA5A5_A5A5),
      reg_row(REG_ORIGIN_X, 32'h0000_FFFF),
      reg_row(REG_ORIGIN_Y, 32'h0000_FFFF),
      reg_row(REG_PITCH, 32'h0000_FFFF),
      reg_row(REG_BPP, 32'd7),
      reg_row(REG_ROW_BYTES, 32'd3),
      reg_row(REG_BASE, 32'hFFFF_FFFF),
      item_row(8'hFF, 1'b0),
      item_row(8'h00, 1'b0),
      item_row(8'h5A, 1'b0),
      item_row(8'hC3, 1'b0),
      item_row(8'h81, 1'b1),
      reg_row(REG_ROW_BYTES, 32'd0),
      item_row(8'h3C, 1'b0),
      item_row(8'h3C, 1'b1),
      reg_row(REG_ROW_BYTES, 32'd3),
      reg_row(REG_BPP, 32'd0),
      item_row(8'h96, 1'b0),
      item_row(8'h69, 1'b0),
      reg_row(REG_ROW_BYTES, 32'd1),
      item_row(8'hF0, 1'b0),
      item_row(8'h0F, 1'b1),
      reg_row(REG_BPP, 32'd5),
      reg_row(REG_ROW_BYTES, 32'd1023),
      reg_row(REG_ORIGIN_X, 32'd0),
      reg_row(REG_ORIGIN_Y, 32'd0),
      reg_row(REG_PITCH, 32'd0),
      reg_row(REG_BASE, 32'd0),
      item_row(8'h12, 1'b0),
      item_row(8'h34, 1'b1),
      reg_row(REG_BPP, 32'd6),
      item_row(8'hAA, 1'b1),
      reg_row(REG_BPP, 32'd1),
      item_row(8'h55, 1'b1),
      reg_row(REG_FG, INVERT_COLOR),
      reg_row(REG_BG, NO_COLOR),
      item_row(8'hFF, 1'b1)
    };

    foreach (rows[i]) begin
      if (rows[i].is_reg) begin
        if (dirty) settle();
        dirty = 1'b0;
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        send_byte(rows[i].bits, rows[i].last, rows[i].typed, rows[i].op);
        dirty = 1'b1;
      end
    end

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      no_gaps = (ph % 4 == 2);
      if (ph == 0 || $urandom_range(0, 2) != 0) write_reg(REG_BASE, pick_word());
      if (ph == 0 || $urandom_range(0, 2) != 0) write_reg(REG_ORIGIN_X, pick_word());
      if (ph == 0 || $urandom_range(0, 2) != 0) write_reg(REG_ORIGIN_Y, pick_word());
      if (ph == 0 || $urandom_range(0, 2) != 0) write_reg(REG_PITCH, pick_word());
      r = $urandom_range(0, 99);
      write_reg(REG_BPP, (r < 70) ? 32'($urandom_range(1, 4)) : 32'($urandom));
      r = $urandom_range(0, 99);
      write_reg(REG_FG, (r < 25) ? NO_COLOR : (r < 45) ? INVERT_COLOR : pick_word());
      r = $urandom_range(0, 99);
      write_reg(REG_BG, (r < 20) ? NO_COLOR : (r < 30) ? INVERT_COLOR : pick_word());
      r = $urandom_range(0, 99);
      if (r < 8) write_reg(REG_ROW_BYTES, 32'd0);
      else if (r < 14) write_reg(REG_ROW_BYTES, 32'd1023);
      else if (r < 80) write_reg(REG_ROW_BYTES, 32'($urandom_range(1, 4)));
      else write_reg(REG_ROW_BYTES, $urandom);

      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (left == 0) begin
          if ($urandom_range(0, 9) == 0) begin
            left = $urandom_range(1, 40);
          end else begin
            rb = (cfg.row_bytes != '0 && cfg.row_bytes <= 6) ? int'(cfg.row_bytes)
                                                            : $urandom_range(1, 6);
            left = rb * $urandom_range(1, 3);
          end
        end
        last = (left == 1) || ($urandom_range(0, 24) == 0);
        send_byte(8'($urandom_range(0, 255)), last, 1'b0, '0);
        left = last ? 0 : left - 1;
      end
    end

    settle();
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
